// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define TBLP_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("text box placer check failed");

// Clocked assertion on the usual clk_i / rst_ni pair.
`define TBLP_ASSERT(lbl, prop) `TBLP_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== sv/tblp_pkg.sv =====
`default_nettype none

package tblp_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned RUNE_W    = 12;
  localparam int unsigned LH_W      = 8;
  localparam int unsigned DIVD_W    = COORD_W + 1;
  localparam int unsigned CNT_W     = $clog2(DIVD_W + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 56;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
  localparam logic [RUNE_W-1:0]  RUNE_MAX  = {RUNE_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_TAB     = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_CTRL    = 2'd3
  } box_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_RIGHT  = 3'd1,
    CFG_BOTTOM = 3'd2,
    CFG_LINE_H = 3'd3,
    CFG_TAB_W  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT,
    ST_PLACE,
    ST_TAB_START,
    ST_TAB_WAIT,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [COORD_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] rem;
  } rem_rsp_t;

endpackage

`default_nettype wire

// ===== sv/tblp_rem.sv =====
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module tblp_rem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tblp_pkg::rem_req_t req_i,
  output tblp_pkg::rem_rsp_t     rsp_o
);

  logic [tblp_pkg::DIVD_W-1:0]  dvd_q, dvd_d;
  logic [tblp_pkg::COORD_W-1:0] rem_q, rem_d;
  logic [tblp_pkg::COORD_W-1:0] div_q, div_d;
  logic [tblp_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [tblp_pkg::DIVD_W-1:0]  shifted;
  logic [tblp_pkg::DIVD_W-1:0]  diff;

  always_comb begin
    shifted = {rem_q, dvd_q[tblp_pkg::DIVD_W-1]};
    diff    = shifted - {1'b0, div_q};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      div_d = req_i.divisor;
      rem_d = '0;
      cnt_d = tblp_pkg::CNT_W'(tblp_pkg::DIVD_W);
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[tblp_pkg::DIVD_W-2:0], 1'b0};
      // subtract when the shifted partial remainder covers the divisor
      rem_d = (shifted >= {1'b0, div_q}) ? diff[tblp_pkg::COORD_W-1:0]
                                         : shifted[tblp_pkg::COORD_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == tblp_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== sv/text_box_layout_placer.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata box fields, tuser kind, tlast
// m_axis    out        m_axis_tvalid/tready       tdata placed box, tuser kind, tlast
// cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One box word at a time. A box that merges into the held text box takes the
// accept and decide steps; any other non-tab box takes accept, decide, emit held
// and place when a box is held, and accept, decide and place when none is held.
// A tab box adds a start step and the tab-stop remainder, one dividend bit per
// cycle in the remainder unit. The last box of a pass adds a final emit step.
// Any cycle the result register is still full delays the emit steps.
// Reset loads the register defaults, clears the held box and puts the cursor
// at (0, 0). Configuration writes are taken in any cycle.
module text_box_layout_placer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // s_axis
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // width[11:0] min_width[23:12] rune_count[35:24] merge_ok[36] first[37]
  // start_x[49:38] start_y[61:50], zero pad
  input  wire logic [tblp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]                       s_axis_tuser,
  input  wire logic                             s_axis_tlast,
  // m_axis
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // box_x[11:0] box_y[23:12] box_width[35:24] box_runes[47:36] frame_full[48],
  // zero pad
  output logic [tblp_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // box_kind[1:0]
  output logic [1:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tblp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tblp_pkg::COORD_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = tblp_pkg::COORD_W;

  // Saturating unsigned add of two coordinate-wide values.
  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? tblp_pkg::COORD_MAX : s[CW-1:0];
  endfunction

  // configuration registers
  logic [CW-1:0]              left_q, right_q, bottom_q, tabw_q;
  logic [tblp_pkg::LH_W-1:0]  lh_q;

  // current box word
  tblp_pkg::box_kind_e        kind_q;
  logic [CW-1:0]              w_q, mw_q;
  logic [tblp_pkg::RUNE_W-1:0] rn_q;
  logic                       mok_q, last_q;

  // held box and cursor
  logic                       pend_valid_q;
  tblp_pkg::box_kind_e        pend_kind_q;
  logic [CW-1:0]              pend_x_q, pend_y_q, pend_width_q;
  logic [tblp_pkg::RUNE_W-1:0] pend_runes_q;
  logic                       pend_merge_q;
  logic [CW-1:0]              cur_x_q, cur_y_q;

  // tab work registers
  logic [CW-1:0]              wx_q, wy_q, tw_q;
  logic                       dneg_q;

  // result register
  logic                       out_valid_q;
  logic [CW-1:0]              ox_q, oy_q, ow_q;
  logic [tblp_pkg::RUNE_W-1:0] orn_q;
  tblp_pkg::box_kind_e        okind_q;
  logic                       ofull_q, olast_q;

  tblp_pkg::state_e           state_q, state_d;

  // sequencer strobes
  logic s_acc, m_acc, out_free;
  logic do_merge, emit_held, store_plain, place_tab, tab_start, tab_store, final_emit;

  // datapath
  logic                       merge_hit;
  logic [CW+1:0]              merge_sum;
  logic [CW-1:0]              need, px, py, adv_x, adv_y, tw_eff, bw_tab;
  logic                       wrap;
  logic [CW:0]                t0;
  logic [CW+1:0]              tab_dist;
  logic [CW:0]                dist_mag;
  logic [CW:0]                tab_adv;
  logic [CW+1:0]              tab_end;
  logic                       tab_fallback;
  logic [tblp_pkg::RUNE_W:0]  rune_sum;

  tblp_pkg::rem_req_t         rem_req;
  tblp_pkg::rem_rsp_t         rem_rsp;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign m_acc    = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Merge test: held and new are both mergeable text and the pair fits.
  assign merge_sum = {2'b00, pend_x_q} + {2'b00, pend_width_q} + {2'b00, w_q};
  assign merge_hit = pend_valid_q && (pend_kind_q == tblp_pkg::KIND_TEXT) &&
                     (kind_q == tblp_pkg::KIND_TEXT) && pend_merge_q && mok_q &&
                     (merge_sum < {2'b00, right_q});
  assign rune_sum  = {1'b0, pend_runes_q} + {1'b0, rn_q};

  // Cursor after the held box: newline drops to the next line.
  always_comb begin
    if (pend_kind_q == tblp_pkg::KIND_NEWLINE) begin
      adv_x = left_q;
      adv_y = sat_add(pend_y_q, CW'(lh_q));
    end else begin
      adv_x = sat_add(pend_x_q, pend_width_q);
      adv_y = pend_y_q;
    end
  end

  // Fit test: text uses width, other kinds use min_width; wrap on overflow.
  assign need = (kind_q == tblp_pkg::KIND_TEXT) ? w_q : mw_q;
  assign wrap = ({1'b0, need} + {1'b0, cur_x_q}) > {1'b0, right_q};
  assign px   = wrap ? left_q : cur_x_q;
  assign py   = wrap ? sat_add(cur_y_q, CW'(lh_q)) : cur_y_q;

  // Tab stop: distance from the left edge to x + tab width, remainder taken
  // on its magnitude; a negative distance rounds toward zero.
  assign tw_eff   = (tabw_q == '0) ? CW'(1) : tabw_q;
  assign t0       = {1'b0, wx_q} + {1'b0, tw_eff};
  assign tab_dist = {1'b0, t0} - {2'b00, left_q};
  assign dist_mag = tab_dist[CW+1] ? (CW+1)'(0) - tab_dist[CW:0] : tab_dist[CW:0];

  assign tab_adv  = dneg_q ? ({1'b0, tw_q} + {1'b0, rem_rsp.rem})
                           : ({1'b0, tw_q} - {1'b0, rem_rsp.rem});
  assign tab_end  = {2'b00, wx_q} + {1'b0, tab_adv};
  assign tab_fallback = (tab_adv < {1'b0, mw_q}) || (tab_end > {2'b00, right_q});
  assign bw_tab   = tab_fallback ? mw_q : tab_adv[CW-1:0];

  assign rem_req.start    = tab_start;
  assign rem_req.dividend = dist_mag;
  assign rem_req.divisor  = tw_eff;

  tblp_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // Sequencer: decide merge, emit held box, place, optional tab, final emit.
  always_comb begin
    state_d     = state_q;
    do_merge    = 1'b0;
    emit_held   = 1'b0;
    store_plain = 1'b0;
    place_tab   = 1'b0;
    tab_start   = 1'b0;
    tab_store   = 1'b0;
    final_emit  = 1'b0;
    unique case (state_q)
      tblp_pkg::ST_IDLE: begin
        if (s_acc) state_d = tblp_pkg::ST_DECIDE;
      end
      tblp_pkg::ST_DECIDE: begin
        if (merge_hit) begin
          do_merge = 1'b1;
          state_d  = last_q ? tblp_pkg::ST_FINAL : tblp_pkg::ST_IDLE;
        end else if (pend_valid_q) begin
          state_d = tblp_pkg::ST_EMIT;
        end else begin
          state_d = tblp_pkg::ST_PLACE;
        end
      end
      tblp_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_held = 1'b1;
          state_d   = tblp_pkg::ST_PLACE;
        end
      end
      tblp_pkg::ST_PLACE: begin
        if (kind_q == tblp_pkg::KIND_TAB) begin
          place_tab = 1'b1;
          state_d   = tblp_pkg::ST_TAB_START;
        end else begin
          store_plain = 1'b1;
          state_d     = last_q ? tblp_pkg::ST_FINAL : tblp_pkg::ST_IDLE;
        end
      end
      tblp_pkg::ST_TAB_START: begin
        tab_start = 1'b1;
        state_d   = tblp_pkg::ST_TAB_WAIT;
      end
      tblp_pkg::ST_TAB_WAIT: begin
        if (rem_rsp.done) begin
          tab_store = 1'b1;
          state_d   = last_q ? tblp_pkg::ST_FINAL : tblp_pkg::ST_IDLE;
        end
      end
      tblp_pkg::ST_FINAL: begin
        if (out_free) begin
          final_emit = 1'b1;
          state_d    = tblp_pkg::ST_IDLE;
        end
      end
      default: state_d = tblp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tblp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: config, held box, cursor, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      right_q      <= tblp_pkg::COORD_MAX;
      bottom_q     <= tblp_pkg::COORD_MAX;
      lh_q         <= tblp_pkg::LH_W'(16);
      tabw_q       <= CW'(64);
      pend_valid_q <= 1'b0;
      pend_kind_q  <= tblp_pkg::KIND_TEXT;
      pend_x_q     <= '0;
      pend_y_q     <= '0;
      pend_width_q <= '0;
      pend_runes_q <= '0;
      pend_merge_q <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tblp_pkg::CFG_LEFT:   left_q   <= cfg_data_i;
          tblp_pkg::CFG_RIGHT:  right_q  <= cfg_data_i;
          tblp_pkg::CFG_BOTTOM: bottom_q <= cfg_data_i;
          tblp_pkg::CFG_LINE_H: lh_q     <= cfg_data_i[tblp_pkg::LH_W-1:0];
          tblp_pkg::CFG_TAB_W:  tabw_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // first box of a pass: drop any held box, load the start cursor
      if (s_acc && s_axis_tdata[37]) begin
        pend_valid_q <= 1'b0;
        cur_x_q      <= s_axis_tdata[49:38];
        cur_y_q      <= s_axis_tdata[61:50];
      end

      if (do_merge) begin
        pend_width_q <= sat_add(pend_width_q, w_q);
        pend_runes_q <= rune_sum[tblp_pkg::RUNE_W] ? tblp_pkg::RUNE_MAX
                                                   : rune_sum[tblp_pkg::RUNE_W-1:0];
      end

      if (emit_held || final_emit) begin
        cur_x_q      <= adv_x;
        cur_y_q      <= adv_y;
        pend_valid_q <= 1'b0;
      end

      if (store_plain) begin
        pend_valid_q <= 1'b1;
        pend_kind_q  <= kind_q;
        pend_x_q     <= px;
        pend_y_q     <= py;
        pend_width_q <= w_q;
        pend_runes_q <= (kind_q == tblp_pkg::KIND_TEXT) ? rn_q : '0;
        pend_merge_q <= mok_q;
      end

      if (tab_store) begin
        pend_valid_q <= 1'b1;
        pend_kind_q  <= tblp_pkg::KIND_TAB;
        pend_x_q     <= wx_q;
        pend_y_q     <= wy_q;
        pend_width_q <= bw_tab;
        pend_runes_q <= '0;
        pend_merge_q <= mok_q;
      end

      if (emit_held || final_emit) begin
        out_valid_q <= 1'b1;
      end else if (m_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= tblp_pkg::box_kind_e'(s_axis_tuser);
      w_q    <= s_axis_tdata[11:0];
      mw_q   <= s_axis_tdata[23:12];
      rn_q   <= s_axis_tdata[35:24];
      mok_q  <= s_axis_tdata[36];
      last_q <= s_axis_tlast;
    end
    if (place_tab) begin
      wx_q <= px;
      wy_q <= py;
    end
    if (tab_start) begin
      tw_q   <= tw_eff;
      dneg_q <= tab_dist[CW+1];
    end
    if (emit_held || final_emit) begin
      ox_q    <= pend_x_q;
      oy_q    <= pend_y_q;
      ow_q    <= pend_width_q;
      orn_q   <= pend_runes_q;
      okind_q <= pend_kind_q;
      ofull_q <= final_emit && (adv_y >= bottom_q);
      olast_q <= final_emit;
    end
  end

  assign s_axis_tready = (state_q == tblp_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, ofull_q, orn_q, ow_q, oy_q, ox_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

// ===== sv/tblp_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module tblp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [tblp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input wire logic                             m_axis_tlast
);

  logic m_stall;
  logic m_final;

  assign m_stall = m_axis_tvalid && !m_axis_tready;
  assign m_final = m_axis_tvalid && m_axis_tlast;

  // a stalled result word holds
  `TBLP_ASSERT(a_out_hold, m_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // one box at a time: no accept in the cycle after an accept
  `TBLP_ASSERT(a_in_busy, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // frame full shows only on the last word of a pass
  `TBLP_ASSERT(a_full_last, (m_axis_tvalid && m_axis_tdata[48]) |-> m_axis_tlast)

  // a fresh final word leaves the input side open
  `TBLP_ASSERT(a_final_idle, (m_final && !$past(m_final)) |-> s_axis_tready)

endmodule

bind text_box_layout_placer tblp_checker u_tblp_checker (.*);

`default_nettype wire
